[design/lrfu_pkg.sv]
// ----------------------------------------------------------------------------
// LRFU score table package
// Shared widths, codes, the state type and the exponent table used by the
// score table.
// ----------------------------------------------------------------------------
package lrfu_pkg;

    // Object slots and the width of an object number.
    localparam int unsigned SLOTS   = 1024;
    localparam int unsigned SLOT_AW = 10;

    // Field widths.
    localparam int unsigned SCORE_W  = 40;
    localparam int unsigned STAMP_W  = 48;
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned LAMBDA_W = 17;
    localparam int unsigned LOG2P_W  = 24;
    localparam int unsigned CFG_W    = 24;

    // Default number of fraction bits of a score.
    localparam int unsigned FRAC_BITS_DEF = 16;

    // Stream payload layout.
    localparam int unsigned IN_TDATA_W  = 96;
    localparam int unsigned IN_TUSER_W  = 1;
    localparam int unsigned OUT_TDATA_W = 40;
    localparam int unsigned OUT_TUSER_W = 2;
    localparam int unsigned IN_IDX_LO   = 0;
    localparam int unsigned IN_TIME_LO  = 10;
    localparam int unsigned IN_COUNT_LO = 58;

    // Largest score, and the exponent cap of 128.0 in Q.32.
    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
    localparam logic [SCORE_W-1:0] EXP_CAP   = 40'h80_0000_0000;

    // Operation carried in tuser.
    typedef enum logic {
        FUNC_ACCESS = 1'b0,
        FUNC_QUERY  = 1'b1
    } t_func;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_COUNT_MODE = 2'd0,
        CFG_LAMBDA     = 2'd1,
        CFG_LOG2_P     = 2'd2
    } t_cfg_reg;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_DECIDE,
        ST_MAG,
        ST_EXP_CHK,
        ST_MAC_LO,
        ST_MAC_HI,
        ST_MAC_ACC,
        ST_EXP_DONE,
        ST_POW,
        ST_POW_UPD,
        ST_SCALE,
        ST_SHIFT,
        ST_WRITE,
        ST_EMIT
    } t_state;

    // round(2^32 * 2^(-2^-i)) for i = 1..16, in Q0.32.
    localparam logic [31:0] POW_TAB [16] = '{
        32'd3037000500, 32'd3611622603, 32'd3938502376, 32'd4112874773,
        32'd4202935003, 32'd4248701965, 32'd4271771996, 32'd4283353945,
        32'd4289156690, 32'd4292061010, 32'd4293513907, 32'd4294240540,
        32'd4294603903, 32'd4294785595, 32'd4294876445, 32'd4294921870
    };

endpackage

[design/lrfu_ram.sv]
// ----------------------------------------------------------------------------
// LRFU generic RAM
// Simple dual-port memory: one write port, one read port with registered
// read data. No reset; contents are undefined until written.
// ----------------------------------------------------------------------------
module lrfu_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/lrfu_crf_table_top.sv]
// ----------------------------------------------------------------------------
// LRFU combined recency/frequency score table
// Keeps one Q.FRAC_BITS score per object. An access decays or grows the old
// score by 2^(-lambda*log2p*delta) and adds one; a query reports the score.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  s_axis    in         tvalid / tready        tuser: func; tdata: object_index,
//                                              time_ms, event_count
//  m_axis    out        tvalid / tready        tdata: crf_value;
//                                              tuser: present, saturated
//  cfg       in         i_cfg_wr_en (no wait)  i_cfg_index, i_cfg_wdata
//
//  After reset a clearing pass over all 1024 slots empties the valid marks;
//  no item is taken meanwhile, configuration writes are.
//  A query passes LOAD, DECIDE and EMIT before ready returns, a first access
//  also WRITE. A repeated access takes longest: its 16-step exponent loop runs
//  through the single shared 32x32 multiplier, with a POW_UPD step per multiply.
//  One item is worked on at a time; a finished result waits in the output
//  register while the next item is accepted and processed.
// ----------------------------------------------------------------------------
module lrfu_crf_table_top #(
    parameter int unsigned FRAC_BITS = lrfu_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input items.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [9:0] object_index, [57:10] time_ms, [89:58] event_count, rest zero
    input  logic [lrfu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] func
    input  logic [lrfu_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    // Result items.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [39:0] crf_value
    output logic [lrfu_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] present, [1] saturated
    output logic [lrfu_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    // Configuration writes.
    input  logic                             i_cfg_wr_en,
    input  logic [1:0]                       i_cfg_index,
    input  logic [lrfu_pkg::CFG_W-1:0]       i_cfg_wdata
);

    import lrfu_pkg::*;

    localparam logic [SCORE_W-1:0] ScoreOne = SCORE_W'(1) << FRAC_BITS;

    // Configuration registers.
    logic                r_count_mode;
    logic [LAMBDA_W-1:0] r_lambda;
    logic [LOG2P_W-1:0]  r_log2_p;

    // Sequencer.
    t_state             r_state, n_state;
    t_state             r_ret;
    logic [SLOT_AW-1:0] r_clr;
    logic               load_out;

    // Item and datapath registers.
    t_func              r_func;
    logic [SLOT_AW-1:0] r_idx;
    logic [STAMP_W-1:0] r_stamp;
    logic [STAMP_W-1:0] r_delta;
    logic [SCORE_W-1:0] r_v;
    logic               r_present;
    logic               r_sat;
    logic [39:0]        r_x;
    logic [31:0]        r_y;
    logic               r_rnd;
    logic [71:0]        r_acc;
    logic [63:0]        r_prod;
    logic [31:0]        r_g;
    logic               r_g_one;
    logic [3:0]         r_cnt;
    logic [15:0]        r_f;
    logic [7:0]         r_sh;

    // Output register.
    logic               r_out_valid;
    logic [SCORE_W-1:0] r_out_value;
    logic               r_out_present;
    logic               r_out_sat;

    // Memories.
    logic                 score_wr_en;
    logic                 stamp_wr_en;
    logic [SLOT_AW-1:0]   stamp_wr_addr;
    logic [STAMP_W:0]     stamp_wr_data;
    logic [SCORE_W-1:0]   rd_score;
    logic [STAMP_W:0]     rd_stamp;

    // Combinational datapath values.
    logic                 s_accept;
    logic                 grow;
    logic [LOG2P_W-1:0]   mag;
    logic [31:0]          mul_a, mul_b;
    logic [63:0]          prod_rnd;
    logic                 pow_bit;
    logic [40:0]          m_val;
    logic                 e_zero, e_cap;
    logic [SCORE_W-1:0]   e_val;
    logic [7:0]           e_ip;
    logic [15:0]          e_fp;
    logic [SCORE_W-1:0]   v_in;
    logic [2*SCORE_W-1:0] v_wide;
    logic                 v_ovf;
    logic [SCORE_W-1:0]   v_sh;
    logic [SCORE_W:0]     v_sum;

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);

    // Sign and magnitude of log2_p.
    assign grow = r_log2_p[LOG2P_W-1];
    assign mag  = grow ? (LOG2P_W'(0) - r_log2_p) : r_log2_p;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_mode <= 1'b0;
            r_lambda     <= LAMBDA_W'(65536);
            r_log2_p     <= LOG2P_W'(65536);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_COUNT_MODE: r_count_mode <= i_cfg_wdata[0];
                CFG_LAMBDA:     r_lambda     <= i_cfg_wdata[LAMBDA_W-1:0];
                CFG_LOG2_P:     r_log2_p     <= i_cfg_wdata[LOG2P_W-1:0];
                default:        ;
            endcase
        end
    end

    // Score memory and stamp memory; the stamp word carries the valid mark on top.
    lrfu_ram #(
        .WIDTH (SCORE_W),
        .DEPTH (SLOTS)
    ) u_score_ram (
        .i_clk     (i_clk),
        .i_wr_en   (score_wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (r_v),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_score)
    );

    lrfu_ram #(
        .WIDTH (STAMP_W + 1),
        .DEPTH (SLOTS)
    ) u_stamp_ram (
        .i_clk     (i_clk),
        .i_wr_en   (stamp_wr_en),
        .i_wr_addr (stamp_wr_addr),
        .i_wr_data (stamp_wr_data),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_stamp)
    );

    // Shared multiplier: operands chosen by the sequencer, product registered.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_MAG: begin
                mul_a = 32'(r_lambda);
                mul_b = 32'(mag);
            end
            ST_MAC_LO: begin
                mul_a = r_x[31:0];
                mul_b = r_y;
            end
            ST_MAC_HI: begin
                mul_a = 32'(r_x[39:32]);
                mul_b = r_y;
            end
            ST_POW: begin
                mul_a = r_g;
                mul_b = POW_TAB[r_cnt];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    assign prod_rnd = r_prod + 64'h0000_0000_8000_0000;
    assign pow_bit  = r_f[~r_cnt];

    // Exponent product m = lambda * |log2_p| and the cap test on m * delta.
    assign m_val  = r_prod[40:0];
    assign e_zero = (m_val == '0) || (r_delta == '0);
    assign e_cap  = m_val[40] || (r_delta[47:40] != '0)
                 || ((m_val[39:32] != '0) && (r_delta[39:32] != '0));

    // Capped exponent split into integer and fraction parts.
    assign e_val = (r_acc > 72'(EXP_CAP)) ? EXP_CAP : r_acc[39:0];
    assign e_ip  = e_val[39:32];
    assign e_fp  = e_val[31:16];

    // Shift by the integer part, then add one, saturating.
    assign v_in   = r_g_one ? r_v : r_acc[71:32];
    assign v_wide = {{SCORE_W{1'b0}}, v_in} << r_sh[5:0];
    always_comb begin
        v_ovf = 1'b0;
        if (!grow) begin
            v_sh = (r_sh >= 8'd40) ? '0 : (v_in >> r_sh[5:0]);
        end else begin
            v_ovf = (v_in != '0)
                 && ((r_sh >= 8'd40) || (v_wide[2*SCORE_W-1:SCORE_W] != '0));
            v_sh  = v_ovf ? SCORE_MAX : v_wide[SCORE_W-1:0];
        end
    end
    assign v_sum = {1'b0, v_sh} + {1'b0, ScoreOne};

    // Sequencer: next state and memory strobes.
    always_comb begin
        n_state       = r_state;
        load_out      = 1'b0;
        score_wr_en   = 1'b0;
        stamp_wr_en   = 1'b0;
        stamp_wr_addr = r_idx;
        stamp_wr_data = {1'b1, r_stamp};
        unique case (r_state)
            ST_CLEAR: begin
                stamp_wr_en   = 1'b1;
                stamp_wr_addr = r_clr;
                stamp_wr_data = '0;
                if (r_clr == SLOT_AW'(SLOTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD:    n_state = ST_DECIDE;
            ST_DECIDE: begin
                if (r_func == FUNC_QUERY) begin
                    n_state = ST_EMIT;
                end else if (!rd_stamp[STAMP_W]) begin
                    n_state = ST_WRITE;
                end else begin
                    n_state = ST_MAG;
                end
            end
            ST_MAG:     n_state = ST_EXP_CHK;
            ST_EXP_CHK: n_state = (e_zero || e_cap) ? ST_EXP_DONE : ST_MAC_LO;
            ST_MAC_LO:  n_state = ST_MAC_HI;
            ST_MAC_HI:  n_state = ST_MAC_ACC;
            ST_MAC_ACC: n_state = r_ret;
            ST_EXP_DONE: n_state = ST_POW;
            ST_POW: begin
                if (pow_bit && !r_g_one) begin
                    n_state = ST_POW_UPD;
                end else if (r_cnt == 4'd15) begin
                    n_state = ST_SCALE;
                end
            end
            ST_POW_UPD: n_state = (r_cnt == 4'd15) ? ST_SCALE : ST_POW;
            ST_SCALE:   n_state = r_g_one ? ST_SHIFT : ST_MAC_LO;
            ST_SHIFT:   n_state = ST_WRITE;
            ST_WRITE: begin
                score_wr_en = 1'b1;
                stamp_wr_en = 1'b1;
                n_state     = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register and clearing counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    // Datapath registers, updated by state.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_func  <= t_func'(s_axis_tuser[0]);
                r_idx   <= s_axis_tdata[IN_IDX_LO +: SLOT_AW];
                r_stamp <= r_count_mode
                         ? STAMP_W'(s_axis_tdata[IN_COUNT_LO +: COUNT_W])
                         : s_axis_tdata[IN_TIME_LO +: STAMP_W];
            end
            ST_DECIDE: begin
                r_delta <= (r_stamp > rd_stamp[STAMP_W-1:0])
                         ? (r_stamp - rd_stamp[STAMP_W-1:0]) : '0;
                if (r_func == FUNC_QUERY) begin
                    r_present <= rd_stamp[STAMP_W];
                    r_v       <= rd_stamp[STAMP_W] ? rd_score : '0;
                    r_sat     <= rd_stamp[STAMP_W] && (rd_score == SCORE_MAX);
                end else begin
                    r_present <= 1'b1;
                    r_v       <= rd_stamp[STAMP_W] ? rd_score : ScoreOne;
                    r_sat     <= 1'b0;
                end
            end
            ST_EXP_CHK: begin
                r_rnd <= 1'b0;
                r_ret <= ST_EXP_DONE;
                if (e_zero) begin
                    r_acc <= '0;
                end else if (e_cap) begin
                    r_acc <= 72'(EXP_CAP);
                end else if (r_delta[39:32] == '0) begin
                    r_x <= m_val[39:0];
                    r_y <= r_delta[31:0];
                end else begin
                    r_x <= r_delta[39:0];
                    r_y <= m_val[31:0];
                end
            end
            ST_MAC_HI: begin
                r_acc <= {8'b0, r_prod} + (r_rnd ? 72'h80_0000_00 : 72'd0);
            end
            ST_MAC_ACC: begin
                r_acc <= r_acc + {r_prod[39:0], 32'b0};
            end
            ST_EXP_DONE: begin
                r_f     <= grow ? (16'd0 - e_fp) : e_fp;
                r_sh    <= grow ? (e_ip + {7'b0, (e_fp != '0)}) : e_ip;
                r_g_one <= 1'b1;
                r_cnt   <= '0;
            end
            ST_POW: begin
                if (pow_bit && r_g_one) begin
                    r_g     <= POW_TAB[r_cnt];
                    r_g_one <= 1'b0;
                end
                if (!(pow_bit && !r_g_one)) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            ST_POW_UPD: begin
                r_g   <= prod_rnd[63:32];
                r_cnt <= r_cnt + 1'b1;
            end
            ST_SCALE: begin
                r_x   <= r_v;
                r_y   <= r_g;
                r_rnd <= 1'b1;
                r_ret <= ST_SHIFT;
            end
            ST_SHIFT: begin
                if (v_sum[SCORE_W]) begin
                    r_v   <= SCORE_MAX;
                    r_sat <= 1'b1;
                end else begin
                    r_v   <= v_sum[SCORE_W-1:0];
                    r_sat <= v_ovf;
                end
            end
            default: ;
        endcase
    end

    // Output register: holds a result until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_value   <= r_v;
            r_out_present <= r_present;
            r_out_sat     <= r_sat;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = {r_out_sat, r_out_present};

    // An accepted item always starts with a memory read.
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == ST_LOAD))
        else $error("accepted item did not start a memory read");

    // The clearing pass ends after its last slot.
    a_clear_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_CLEAR) && (r_clr == SLOT_AW'(SLOTS - 1)))
        |=> (r_state == ST_IDLE))
        else $error("clearing pass did not end");

    // A stored score is never below one.
    a_score_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE) |-> (r_v >= ScoreOne))
        else $error("stored score below one");

    // Saturation is only reported for an object that has a score.
    a_sat_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tuser[0])
        else $error("saturated flag without a score");

endmodule
